/* design/sblit_pkg.sv */
`default_nettype none

package sblit_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR,
      ST_DECIDE,
      ST_SCAN,
      ST_DRAIN,
      ST_DIV,
      ST_OUT
   } state_type;

   parameter int CSR_IDX_W = 3;
   parameter logic [CSR_IDX_W-1:0] CSR_CLIP_RIGHT  = 3'd0;
   parameter logic [CSR_IDX_W-1:0] CSR_CLIP_BOTTOM = 3'd1;
   parameter logic [CSR_IDX_W-1:0] CSR_START_X     = 3'd2;
   parameter logic [CSR_IDX_W-1:0] CSR_START_Y     = 3'd3;
   parameter logic [CSR_IDX_W-1:0] CSR_STEP_X      = 3'd4;
   parameter logic [CSR_IDX_W-1:0] CSR_STEP_Y      = 3'd5;

   parameter logic REQ_STORE   = 1'b0;
   parameter logic REQ_COMPUTE = 1'b1;

   parameter int CLIP_W    = 9;
   parameter int NUM_CH    = 4;
   parameter int ACC_W     = 24;
   parameter int WT_W      = 17;
   parameter int CNT_W     = 5;
   parameter int DIV_STEPS = 13;

   parameter logic [CLIP_W-1:0] CLIP_RESET = 9'd256;
   parameter logic [31:0] STEP_RESET       = 32'd65536;
   parameter logic signed [31:0] BOX_MIN_STEP = 32'sd111412;
   parameter logic signed [31:0] BOX_BIG_STEP = 32'sd196608;
   parameter logic [WT_W-1:0] ONE_FX = 17'd65536;

endpackage

`default_nettype wire

/* design/scaled_blit_bilinear_box.sv */
// A store item writes one word of the source memory when its column and row lie inside it.
// A compute item walks a window of 4 reads in interpolation mode, or of 9 or 25
// window steps in box mode followed by a 13-step divider; a position outside the
// clip skips the walk. No new item is accepted until the result of the last one is
// registered; the single read port and the divider set this.
// Reset restores the control state and the CSRs; the datapath registers and the source memory are not cleared.
`default_nettype none

module scaled_blit_bilinear_box #(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [7:0]  req_src_col,
   input  wire logic [7:0]  req_src_row,
   input  wire logic [31:0] req_pixel_in,
   input  wire logic [11:0] req_dst_col,
   input  wire logic [11:0] req_dst_row,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_written,
   output logic [31:0]      rsp_out_pixel,
   input  wire logic        csr_wr_en,
   input  wire logic [sblit_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0] csr_wr_data
);

   localparam int CRW = ($clog2(MAX_SRC_WIDTH + 1) > sblit_pkg::CLIP_W) ?
                        $clog2(MAX_SRC_WIDTH + 1) : sblit_pkg::CLIP_W;
   localparam int CBW = ($clog2(MAX_SRC_HEIGHT + 1) > sblit_pkg::CLIP_W) ?
                        $clog2(MAX_SRC_HEIGHT + 1) : sblit_pkg::CLIP_W;
   localparam int CW    = $clog2(MAX_SRC_WIDTH);
   localparam int RW    = $clog2(MAX_SRC_HEIGHT);
   localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int PXW   = CRW + 2;
   localparam int PYW   = CBW + 2;
   localparam int NCH   = sblit_pkg::NUM_CH;
   localparam int ACC_W = sblit_pkg::ACC_W;
   localparam int WT_W  = sblit_pkg::WT_W;
   localparam int CNT_W = sblit_pkg::CNT_W;

   sblit_pkg::state_type state_ff, state_in;

   logic [sblit_pkg::CLIP_W-1:0] clip_right_ff, clip_right_in;
   logic [sblit_pkg::CLIP_W-1:0] clip_bottom_ff, clip_bottom_in;
   logic [31:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [31:0] step_x_ff, step_x_in, step_y_ff, step_y_in;

   logic [31:0] prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic [31:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [CRW-1:0] ix_ff, ix_in;
   logic [CBW-1:0] iy_ff, iy_in;
   logic [15:0] xf_ff, xf_in, yf_ff, yf_in, w11_ff, w11_in;
   logic box_ff, box_in, big_ff, big_in;
   logic lastx_ff, lastx_in, lasty_ff, lasty_in;
   logic wrote_ff, wrote_in;
   logic [2:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic rd_vld_ff, rd_vld_in;
   logic [WT_W-1:0] wt_ff, wt_in;
   logic [31:0] rdata_ff;
   logic [ACC_W-1:0] acc_ff [NCH];
   logic [ACC_W-1:0] acc_in [NCH];
   logic [CNT_W-1:0] rem_ff [NCH];
   logic [CNT_W-1:0] rem_in [NCH];
   logic [3:0] div_cnt_ff, div_cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_written_ff, rsp_written_in;
   logic [31:0] rsp_pixel_ff, rsp_pixel_in;

   logic [31:0] image_mem [DEPTH];
   logic mem_we;
   logic [AW-1:0] mem_waddr, rd_addr;

   logic [CRW-1:0] cr;
   logic [CBW-1:0] cb;
   logic [15:0] ix_full, iy_full;
   logic in_x, in_y, box_mode, big_win, last_x, last_y;
   logic [15:0] xf_eff, yf_eff;
   logic [31:0] w11_prod;
   logic [2:0] half, size_m1, x_off, y_off;
   logic [PXW-1:0] xp;
   logic [PYW-1:0] yp;
   logic xp_ok, yp_ok, pos_ok, scan_last;
   logic [WT_W-1:0] weight;
   logic [ACC_W:0] mul [NCH];
   logic [CNT_W:0] rem_next [NCH];
   logic [NCH-1:0] q_bit;
   logic [31:0] pix_res;

   assign req_stall     = (state_ff != sblit_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_written   = rsp_written_ff;
   assign rsp_out_pixel = rsp_pixel_ff;

   // Position decode.
   always_comb begin
      cr = (CRW'(clip_right_ff) > CRW'(MAX_SRC_WIDTH)) ?
           CRW'(MAX_SRC_WIDTH) : CRW'(clip_right_ff);
      cb = (CBW'(clip_bottom_ff) > CBW'(MAX_SRC_HEIGHT)) ?
           CBW'(MAX_SRC_HEIGHT) : CBW'(clip_bottom_ff);
      ix_full  = cx_ff[31:16];
      iy_full  = cy_ff[31:16];
      in_x     = !ix_full[15] && (ix_full < 16'(cr));
      in_y     = !iy_full[15] && (iy_full < 16'(cb));
      box_mode = ($signed(step_x_ff) >= sblit_pkg::BOX_MIN_STEP) &&
                 ($signed(step_y_ff) >= sblit_pkg::BOX_MIN_STEP);
      big_win  = ($signed(step_x_ff) > sblit_pkg::BOX_BIG_STEP) ||
                 ($signed(step_y_ff) > sblit_pkg::BOX_BIG_STEP);
      last_x   = (ix_full == 16'(cr) - 16'd1);
      last_y   = (iy_full == 16'(cb) - 16'd1);
      xf_eff   = last_x ? 16'd0 : cx_ff[15:0];
      yf_eff   = last_y ? 16'd0 : cy_ff[15:0];
      w11_prod = xf_eff * yf_eff;
   end

   // Window walk.
   always_comb begin
      half    = box_ff ? (big_ff ? 3'd2 : 3'd1) : 3'd0;
      size_m1 = box_ff ? (big_ff ? 3'd4 : 3'd2) : 3'd1;
      x_off   = box_ff ? dx_ff : {2'b00, dx_ff[0] & !lastx_ff};
      y_off   = box_ff ? dy_ff : {2'b00, dy_ff[0] & !lasty_ff};
      xp      = PXW'(ix_ff) + PXW'(x_off) - PXW'(half);
      yp      = PYW'(iy_ff) + PYW'(y_off) - PYW'(half);
      xp_ok   = !xp[PXW-1] && (xp[PXW-2:0] < (PXW-1)'(cr));
      yp_ok   = !yp[PYW-1] && (yp[PYW-2:0] < (PYW-1)'(cb));
      pos_ok  = box_ff ? (xp_ok && yp_ok) : 1'b1;
      rd_addr = AW'(yp[RW-1:0]) * AW'(MAX_SRC_WIDTH) + AW'(xp[CW-1:0]);
      scan_last = (dx_ff == size_m1) && (dy_ff == size_m1);
      if (box_ff) begin
         weight = WT_W'(1);
      end else begin
         case ({dy_ff[0], dx_ff[0]})
            2'b00:   weight = sblit_pkg::ONE_FX - {1'b0, yf_ff} - {1'b0, xf_ff}
                              + {1'b0, w11_ff};
            2'b01:   weight = {1'b0, xf_ff - w11_ff};
            2'b10:   weight = {1'b0, yf_ff - w11_ff};
            default: weight = {1'b0, w11_ff};
         endcase
      end
      mem_waddr = AW'(req_src_row) * AW'(MAX_SRC_WIDTH) + AW'(req_src_col);
   end

   // Channel arithmetic: weighted accumulate, divider step and result packing.
   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         mul[c] = (ACC_W + 1)'(rdata_ff[8*c +: 8]) * (ACC_W + 1)'(wt_ff);
         rem_next[c] = {rem_ff[c], acc_ff[c][sblit_pkg::DIV_STEPS-1]};
         q_bit[c] = (rem_next[c] >= {1'b0, cnt_ff});
         pix_res[8*c +: 8] = box_ff ? acc_ff[c][7:0] : acc_ff[c][23:16];
      end
   end

   always_comb begin
      state_in       = state_ff;
      clip_right_in  = clip_right_ff;
      clip_bottom_in = clip_bottom_ff;
      start_x_in     = start_x_ff;
      start_y_in     = start_y_ff;
      step_x_in      = step_x_ff;
      step_y_in      = step_y_ff;
      prod_x_in      = prod_x_ff;
      prod_y_in      = prod_y_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      ix_in          = ix_ff;
      iy_in          = iy_ff;
      xf_in          = xf_ff;
      yf_in          = yf_ff;
      w11_in         = w11_ff;
      box_in         = box_ff;
      big_in         = big_ff;
      lastx_in       = lastx_ff;
      lasty_in       = lasty_ff;
      wrote_in       = wrote_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      cnt_in         = cnt_ff;
      rd_vld_in      = 1'b0;
      wt_in          = wt_ff;
      div_cnt_in     = div_cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_written_in = rsp_written_ff;
      rsp_pixel_in   = rsp_pixel_ff;
      mem_we         = 1'b0;
      for (int c = 0; c < NCH; c++) begin
         acc_in[c] = acc_ff[c];
         rem_in[c] = rem_ff[c];
      end

      if (csr_wr_en) begin
         case (csr_index)
            sblit_pkg::CSR_CLIP_RIGHT:  clip_right_in  = csr_wr_data[sblit_pkg::CLIP_W-1:0];
            sblit_pkg::CSR_CLIP_BOTTOM: clip_bottom_in = csr_wr_data[sblit_pkg::CLIP_W-1:0];
            sblit_pkg::CSR_START_X:     start_x_in     = csr_wr_data;
            sblit_pkg::CSR_START_Y:     start_y_in     = csr_wr_data;
            sblit_pkg::CSR_STEP_X:      step_x_in      = csr_wr_data;
            sblit_pkg::CSR_STEP_Y:      step_y_in      = csr_wr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (rd_vld_ff) begin
         for (int c = 0; c < NCH; c++) begin
            acc_in[c] = acc_ff[c] + mul[c][ACC_W-1:0];
         end
      end

      case (state_ff)
         sblit_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_type == sblit_pkg::REQ_STORE) begin
                  mem_we = (32'(req_src_col) < 32'(MAX_SRC_WIDTH)) &&
                           (32'(req_src_row) < 32'(MAX_SRC_HEIGHT));
               end else begin
                  prod_x_in = 32'(32'(req_dst_col) * step_x_ff);
                  prod_y_in = 32'(32'(req_dst_row) * step_y_ff);
                  state_in  = sblit_pkg::ST_ADDR;
               end
            end
         end
         sblit_pkg::ST_ADDR: begin
            cx_in    = start_x_ff + prod_x_ff;
            cy_in    = start_y_ff + prod_y_ff;
            state_in = sblit_pkg::ST_DECIDE;
         end
         sblit_pkg::ST_DECIDE: begin
            ix_in    = ix_full[CRW-1:0];
            iy_in    = iy_full[CBW-1:0];
            xf_in    = xf_eff;
            yf_in    = yf_eff;
            w11_in   = w11_prod[31:16];
            box_in   = box_mode;
            big_in   = big_win;
            lastx_in = last_x;
            lasty_in = last_y;
            wrote_in = in_x && in_y;
            dx_in    = 3'd0;
            dy_in    = 3'd0;
            cnt_in   = '0;
            for (int c = 0; c < NCH; c++) begin
               acc_in[c] = '0;
            end
            state_in = (in_x && in_y) ? sblit_pkg::ST_SCAN : sblit_pkg::ST_OUT;
         end
         sblit_pkg::ST_SCAN: begin
            rd_vld_in = pos_ok;
            wt_in     = weight;
            cnt_in    = cnt_ff + CNT_W'(pos_ok);
            if (dx_ff == size_m1) begin
               dx_in = 3'd0;
               dy_in = dy_ff + 3'd1;
            end else begin
               dx_in = dx_ff + 3'd1;
            end
            if (scan_last) begin
               state_in = sblit_pkg::ST_DRAIN;
            end
         end
         sblit_pkg::ST_DRAIN: begin
            div_cnt_in = 4'd0;
            for (int c = 0; c < NCH; c++) begin
               rem_in[c] = '0;
            end
            state_in = box_ff ? sblit_pkg::ST_DIV : sblit_pkg::ST_OUT;
         end
         sblit_pkg::ST_DIV: begin
            for (int c = 0; c < NCH; c++) begin
               rem_in[c] = q_bit[c] ? CNT_W'(rem_next[c] - {1'b0, cnt_ff})
                                    : rem_next[c][CNT_W-1:0];
               acc_in[c] = {acc_ff[c][ACC_W-2:0], q_bit[c]};
            end
            div_cnt_in = div_cnt_ff + 4'd1;
            if (div_cnt_ff == 4'(sblit_pkg::DIV_STEPS - 1)) begin
               state_in = sblit_pkg::ST_OUT;
            end
         end
         sblit_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_written_in = wrote_ff;
               rsp_pixel_in   = wrote_ff ? pix_res : 32'd0;
               state_in       = sblit_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sblit_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sblit_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         rd_vld_ff      <= 1'b0;
         clip_right_ff  <= sblit_pkg::CLIP_RESET;
         clip_bottom_ff <= sblit_pkg::CLIP_RESET;
         start_x_ff     <= 32'd0;
         start_y_ff     <= 32'd0;
         step_x_ff      <= sblit_pkg::STEP_RESET;
         step_y_ff      <= sblit_pkg::STEP_RESET;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         rd_vld_ff      <= rd_vld_in;
         clip_right_ff  <= clip_right_in;
         clip_bottom_ff <= clip_bottom_in;
         start_x_ff     <= start_x_in;
         start_y_ff     <= start_y_in;
         step_x_ff      <= step_x_in;
         step_y_ff      <= step_y_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_x_ff      <= prod_x_in;
      prod_y_ff      <= prod_y_in;
      cx_ff          <= cx_in;
      cy_ff          <= cy_in;
      ix_ff          <= ix_in;
      iy_ff          <= iy_in;
      xf_ff          <= xf_in;
      yf_ff          <= yf_in;
      w11_ff         <= w11_in;
      box_ff         <= box_in;
      big_ff         <= big_in;
      lastx_ff       <= lastx_in;
      lasty_ff       <= lasty_in;
      wrote_ff       <= wrote_in;
      dx_ff          <= dx_in;
      dy_ff          <= dy_in;
      cnt_ff         <= cnt_in;
      wt_ff          <= wt_in;
      div_cnt_ff     <= div_cnt_in;
      rsp_written_ff <= rsp_written_in;
      rsp_pixel_ff   <= rsp_pixel_in;
      for (int c = 0; c < NCH; c++) begin
         acc_ff[c] <= acc_in[c];
         rem_ff[c] <= rem_in[c];
      end
   end

   // Source image: one write port for stores, one registered read port for the window walk.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         image_mem[mem_waddr] <= req_pixel_in;
      end
      rdata_ff <= image_mem[rd_addr];
   end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IMG_W = 256;
   localparam int IMG_H = 256;
   localparam logic [31:0] UNIT = 32'h0001_0000;
   localparam logic [31:0] HALF = 32'h0000_8000;

   typedef struct {
      logic        kind;
      logic [7:0]  src_col;
      logic [7:0]  src_row;
      logic [31:0] pixel;
      logic [11:0] dst_col;
      logic [11:0] dst_row;
   } blit_req_type;

   typedef struct {
      logic        written;
      logic [31:0] pixel;
   } blit_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = sblit_pkg::REQ_STORE;
   logic [7:0]  req_src_col = '0;
   logic [7:0]  req_src_row = '0;
   logic [31:0] req_pixel_in = '0;
   logic [11:0] req_dst_col = '0;
   logic [11:0] req_dst_row = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_written;
   logic [31:0] rsp_out_pixel;
   logic        csr_wr_en = 1'b0;
   logic [sblit_pkg::CSR_IDX_W-1:0] csr_index = sblit_pkg::CSR_CLIP_RIGHT;
   logic [31:0] csr_wr_data = '0;

   logic [8:0]  win_clip_r = 9'd256;
   logic [8:0]  win_clip_b = 9'd256;
   logic [31:0] win_start_x = '0;
   logic [31:0] win_start_y = '0;
   logic [31:0] win_step_x = UNIT;
   logic [31:0] win_step_y = UNIT;

   logic [31:0] image_mem [0:IMG_W*IMG_H-1];
   bit          image_set [0:IMG_W*IMG_H-1];
   int unsigned touched[$];
   blit_rsp_type pixel_queue[$];

   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int n_fail = 0;
   int n_stores = 0;
   int n_computes = 0;
   int n_written = 0;
   int n_box = 0;
   int n_settings = 0;

   scaled_blit_bilinear_box dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_src_col   (req_src_col),
      .req_src_row   (req_src_row),
      .req_pixel_in  (req_pixel_in),
      .req_dst_col   (req_dst_col),
      .req_dst_row   (req_dst_row),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_written   (rsp_written),
      .rsp_out_pixel (rsp_out_pixel),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [31:0] fetch(input int row, input int col);
      int unsigned addr;
      addr = row * IMG_W + col;
      touched.push_back(addr);
      return image_mem[addr];
   endfunction

   function automatic logic [31:0] blend2(input logic [31:0] p0, p1, frac);
      logic [31:0] f;
      logic [63:0] v;
      logic [31:0] r;
      f = UNIT - frac;
      r = '0;
      for (int c = 0; c < 4; c++) begin
         v = (64'(p0[8*c +: 8]) * f + 64'(p1[8*c +: 8]) * frac) >> 16;
         r[8*c +: 8] = v[7:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] blend4(input logic [31:0] p00, p01, p10, p11, xf, yf);
      logic [31:0] w00, w01, w10, w11;
      logic [63:0] v;
      logic [31:0] r;
      w11 = (xf * yf) >> 16;
      w10 = yf - w11;
      w01 = xf - w11;
      w00 = UNIT - yf - xf + w11;
      r = '0;
      for (int c = 0; c < 4; c++) begin
         v = (64'(p00[8*c +: 8]) * w00 + 64'(p01[8*c +: 8]) * w01 +
              64'(p10[8*c +: 8]) * w10 + 64'(p11[8*c +: 8]) * w11) >> 16;
         r[8*c +: 8] = v[7:0];
      end
      return r;
   endfunction

   function automatic blit_rsp_type sample_pixel(input logic [11:0] dcol, drow,
                                                 output bit boxed);
      blit_rsp_type res;
      int cr, cb, ix, iy, size, half, cnt;
      int sum [4];
      logic [31:0] cx, cy, p, xf, yf;
      logic signed [31:0] sx, sy;
      bit lastx, lasty;
      res.written = 1'b0;
      res.pixel = '0;
      boxed = 1'b0;
      cr = (win_clip_r > IMG_W) ? IMG_W : int'(win_clip_r);
      cb = (win_clip_b > IMG_H) ? IMG_H : int'(win_clip_b);
      cx = win_start_x + 32'(dcol) * win_step_x;
      cy = win_start_y + 32'(drow) * win_step_y;
      ix = $signed(cx) >>> 16;
      iy = $signed(cy) >>> 16;
      xf = {16'h0, cx[15:0]};
      yf = {16'h0, cy[15:0]};
      sx = win_step_x;
      sy = win_step_y;
      if (cr < 1 || cb < 1 || ix < 0 || ix >= cr || iy < 0 || iy >= cb)
         return res;
      res.written = 1'b1;
      if (sx >= sblit_pkg::BOX_MIN_STEP && sy >= sblit_pkg::BOX_MIN_STEP) begin
         boxed = 1'b1;
         size = ((sx > sy ? sx : sy) > sblit_pkg::BOX_BIG_STEP) ? 5 : 3;
         half = size / 2;
         cnt = 0;
         for (int c = 0; c < 4; c++) sum[c] = 0;
         for (int yp = iy - half; yp <= iy + half; yp++) begin
            if (yp >= 0 && yp < cb) begin
               for (int xp = ix - half; xp <= ix + half; xp++) begin
                  if (xp >= 0 && xp < cr) begin
                     p = fetch(yp, xp);
                     for (int c = 0; c < 4; c++) sum[c] += p[8*c +: 8];
                     cnt++;
                  end
               end
            end
         end
         for (int c = 0; c < 4; c++) res.pixel[8*c +: 8] = 8'(sum[c] / cnt);
      end else begin
         lastx = (ix == cr - 1);
         lasty = (iy == cb - 1);
         if (!lastx && !lasty) begin
            res.pixel = blend4(fetch(iy, ix), fetch(iy, ix + 1), fetch(iy + 1, ix),
                               fetch(iy + 1, ix + 1), xf, yf);
         end else if (lastx && !lasty) begin
            res.pixel = blend2(fetch(iy, ix), fetch(iy + 1, ix), yf);
         end else if (!lastx) begin
            res.pixel = blend2(fetch(iy, ix), fetch(iy, ix + 1), xf);
         end else begin
            res.pixel = fetch(iy, ix);
         end
      end
      return res;
   endfunction

   function automatic blit_req_type random_fields();
      blit_req_type item;
      item.kind = 1'($urandom_range(0, 1));
      item.src_col = 8'($urandom_range(0, 255));
      item.src_row = 8'($urandom_range(0, 255));
      item.pixel = $urandom;
      item.dst_col = 12'($urandom_range(0, 4095));
      item.dst_row = 12'($urandom_range(0, 4095));
      return item;
   endfunction

   function automatic logic [11:0] aim_index(input logic [31:0] start, step,
                                             input logic [8:0] clip);
      int eff;
      longint target, d;
      eff = (clip > IMG_W) ? IMG_W : int'(clip);
      if (eff < 1 || step == 0)
         return 12'($urandom_range(0, 4095));
      target = longint'($urandom_range(0, eff * 65536 - 1));
      d = (target - longint'($signed(start))) / longint'($signed(step));
      if (d < 0 || d > 4095)
         return 12'($urandom_range(0, 4095));
      return d[11:0];
   endfunction

   function automatic logic [8:0] pick_clip();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 9'($urandom_range(1, 8));
      else if (roll < 70) return 9'($urandom_range(9, 256));
      else if (roll < 80) return 9'd256;
      else if (roll < 92) return 9'($urandom_range(257, 511));
      else return 9'd0;
   endfunction

   task automatic send_item(input blit_req_type item);
      blit_rsp_type want;
      bit boxed;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= item.kind;
      req_src_col <= item.src_col;
      req_src_row <= item.src_row;
      req_pixel_in <= item.pixel;
      req_dst_col <= item.dst_col;
      req_dst_row <= item.dst_row;
      do @(posedge clock); while (req_stall);
      if (item.kind == sblit_pkg::REQ_STORE) begin
         image_mem[{item.src_row, item.src_col}] = item.pixel;
         image_set[{item.src_row, item.src_col}] = 1'b1;
         n_stores++;
      end else begin
         want = sample_pixel(item.dst_col, item.dst_row, boxed);
         pixel_queue.push_back(want);
         n_computes++;
         if (want.written) n_written++;
         if (want.written && boxed) n_box++;
      end
   endtask

   task automatic store_px(input int row, col, input logic [31:0] value);
      blit_req_type item;
      item = random_fields();
      item.kind = sblit_pkg::REQ_STORE;
      item.src_row = 8'(row);
      item.src_col = 8'(col);
      item.pixel = value;
      send_item(item);
   endtask

   // Every source pixel the item will read is stored first.
   task automatic issue_compute(input logic [11:0] dcol, drow);
      blit_req_type item;
      bit boxed;
      int unsigned addrs[$];
      touched.delete();
      void'(sample_pixel(dcol, drow, boxed));
      addrs = touched;
      foreach (addrs[i]) begin
         if (!image_set[addrs[i]])
            store_px(addrs[i] / IMG_W, addrs[i] % IMG_W, $urandom);
      end
      item = random_fields();
      item.kind = sblit_pkg::REQ_COMPUTE;
      item.dst_col = dcol;
      item.dst_row = drow;
      send_item(item);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_write(input logic [sblit_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      case (idx)
         sblit_pkg::CSR_CLIP_RIGHT:  win_clip_r = data[8:0];
         sblit_pkg::CSR_CLIP_BOTTOM: win_clip_b = data[8:0];
         sblit_pkg::CSR_START_X:     win_start_x = data;
         sblit_pkg::CSR_START_Y:     win_start_y = data;
         sblit_pkg::CSR_STEP_X:      win_step_x = data;
         sblit_pkg::CSR_STEP_Y:      win_step_y = data;
         default: ;
      endcase
   endtask

   task automatic write_window(input logic [8:0] cr, cb, input logic [31:0] x0, y0, dx, dy);
      settle();
      csr_write(sblit_pkg::CSR_CLIP_RIGHT, {23'h0, cr});
      csr_write(sblit_pkg::CSR_CLIP_BOTTOM, {23'h0, cb});
      csr_write(sblit_pkg::CSR_START_X, x0);
      csr_write(sblit_pkg::CSR_START_Y, y0);
      csr_write(sblit_pkg::CSR_STEP_X, dx);
      csr_write(sblit_pkg::CSR_STEP_Y, dy);
      csr_wr_en <= 1'b0;
      n_settings++;
   endtask

   task automatic test_default_window();
      store_px(0, 0, 32'h0000_0000);
      store_px(0, 1, 32'hFFFF_FFFF);
      store_px(255, 255, 32'hFFFF_FFFF);
      store_px(255, 0, 32'h8080_8080);
      issue_compute(12'd0, 12'd0);
      issue_compute(12'd255, 12'd255);
      issue_compute(12'd255, 12'd0);
      issue_compute(12'd0, 12'd255);
      issue_compute(12'd4095, 12'd4095);
      issue_compute(12'd256, 12'd3);
   endtask

   task automatic test_clip_bounds();
      write_window(9'd0, 9'd256, 32'h0, 32'h0, UNIT, UNIT);
      issue_compute(12'd0, 12'd0);
      write_window(9'd1, 9'd1, 32'h0, 32'h0, UNIT, UNIT);
      issue_compute(12'd0, 12'd0);
      issue_compute(12'd1, 12'd0);
      write_window(9'd511, 9'd300, HALF, HALF, UNIT, UNIT);
      issue_compute(12'd254, 12'd254);
      issue_compute(12'd255, 12'd10);
      issue_compute(12'd10, 12'd255);
   endtask

   task automatic test_position_wrap();
      write_window(9'd256, 9'd256, 32'h7FFF_FFFF, 32'h8000_0000, UNIT, UNIT);
      issue_compute(12'd0, 12'd0);
      write_window(9'd256, 9'd256, 32'h7FFF_0000, 32'h0, UNIT, 32'h8000_0000);
      issue_compute(12'd1, 12'd0);
      issue_compute(12'd0, 12'd1);
      write_window(9'd16, 9'd16, 32'hFFFE_8000, 32'h0000_4000, UNIT, 32'h7FFF_FFFF);
      issue_compute(12'd2, 12'd0);
      issue_compute(12'd17, 12'd0);
      issue_compute(12'd2, 12'd1);
   endtask

   task automatic test_box_windows();
      write_window(9'd256, 9'd256, 32'h0, 32'h0, sblit_pkg::BOX_MIN_STEP,
                   sblit_pkg::BOX_MIN_STEP);
      issue_compute(12'd0, 12'd0);
      issue_compute(12'd10, 12'd10);
      write_window(9'd256, 9'd256, 32'h0, 32'h0, sblit_pkg::BOX_MIN_STEP - 1,
                   sblit_pkg::BOX_MIN_STEP);
      issue_compute(12'd3, 12'd3);
      write_window(9'd256, 9'd256, 32'h0, 32'h0, sblit_pkg::BOX_BIG_STEP,
                   sblit_pkg::BOX_BIG_STEP);
      issue_compute(12'd85, 12'd85);
      write_window(9'd256, 9'd256, 32'h0, 32'h0, sblit_pkg::BOX_BIG_STEP + 1,
                   sblit_pkg::BOX_MIN_STEP);
      issue_compute(12'd0, 12'd0);
      issue_compute(12'd20, 12'd20);
      write_window(9'd256, 9'd256, 32'h0, 32'h0, 32'h7FFF_FFFF, sblit_pkg::BOX_MIN_STEP);
      issue_compute(12'd0, 12'd5);
      issue_compute(12'd1, 12'd0);
   endtask

   task automatic pick_window();
      logic [8:0] cr, cb;
      logic [31:0] x0, y0, dx, dy, tmp;
      int fam;
      fam = $urandom_range(0, 3);
      cr = pick_clip();
      cb = pick_clip();
      case (fam)
         0: begin
            dx = $urandom_range(1, sblit_pkg::BOX_MIN_STEP - 1);
            dy = $urandom_range(1, sblit_pkg::BOX_MIN_STEP - 1);
            if ($urandom_range(0, 3) == 0) dx = 32'h0 - dx;
            if ($urandom_range(0, 3) == 0) dy = 32'h0 - dy;
         end
         1: begin
            dx = $urandom_range(sblit_pkg::BOX_MIN_STEP, 32'h0006_0000);
            dy = $urandom_range(sblit_pkg::BOX_MIN_STEP, 32'h0006_0000);
         end
         2: begin
            dx = $urandom_range(sblit_pkg::BOX_MIN_STEP, 32'h0006_0000);
            dy = $urandom_range(1, sblit_pkg::BOX_MIN_STEP - 1);
            if ($urandom_range(0, 1) == 1) begin
               tmp = dx;
               dx = dy;
               dy = tmp;
            end
         end
         default: begin
            dx = $urandom;
            dy = $urandom;
         end
      endcase
      if (fam == 3) begin
         x0 = $urandom;
         y0 = $urandom;
      end else begin
         x0 = 32'($urandom_range(0, 258 * 65536)) - 32'h0002_0000;
         y0 = 32'($urandom_range(0, 258 * 65536)) - 32'h0002_0000;
      end
      write_window(cr, cb, x0, y0, dx, dy);
   endtask

   task automatic test_random_traffic(input int n_items, idle_pct, stall_pct);
      int done, phase_len, base;
      logic [11:0] dcol, drow;
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      base = n_stores + n_computes;
      done = 0;
      while (done < n_items) begin
         pick_window();
         phase_len = $urandom_range(10, 40);
         for (int k = 0; k < phase_len && done < n_items; k++) begin
            if ($urandom_range(0, 99) < 20) begin
               store_px($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
            end else begin
               if ($urandom_range(0, 99) < 85) begin
                  dcol = aim_index(win_start_x, win_step_x, win_clip_r);
                  drow = aim_index(win_start_y, win_step_y, win_clip_b);
               end else begin
                  dcol = 12'($urandom_range(0, 4095));
                  drow = 12'($urandom_range(0, 4095));
               end
               issue_compute(dcol, drow);
            end
            done = n_stores + n_computes - base;
         end
      end
   endtask

   always @(posedge clock) begin
      blit_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_queue.size() == 0) begin
            $error("unexpected item: written=%0b out_pixel=%h", rsp_written, rsp_out_pixel);
            n_fail++;
         end else begin
            want = pixel_queue.pop_front();
            if (rsp_written !== want.written) begin
               $error("written: expected %0b, got %0b", want.written, rsp_written);
               n_fail++;
            end
            if (rsp_out_pixel !== want.pixel) begin
               $error("out_pixel: expected %h, got %h", want.pixel, rsp_out_pixel);
               n_fail++;
            end
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct = 32;
      rsp_stall_pct = 79;
      test_default_window();
      test_clip_bounds();
      test_position_wrap();
      test_box_windows();
      test_random_traffic(130, 32, 79);
      test_random_traffic(130, 79, 32);
      test_random_traffic(130, 0, 0);
      settle();
      $display("Covered %0d stores and %0d compute items across %0d window settings.",
               n_stores, n_computes, n_settings);
      $display("%0d computes produced a pixel, %0d of them by box averaging.",
               n_written, n_box);
      if (n_fail == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire

/* scaled_blit_bilinear_box.f */
design/sblit_pkg.sv
design/scaled_blit_bilinear_box.sv
verif/tb_top.sv
